// ----- src/led_strip_effect_generator_core_macros.svh -----
// assertion macros shared by the led strip effect generator rtl
`ifndef LED_STRIP_EFFECT_GENERATOR_CORE_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LSEG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define LSEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define LSEG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LSEG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/lseg_pkg.sv -----
// shared types, constants and arithmetic helpers for the led strip effect generator
package lseg_pkg;

    localparam int NUM_LEDS_DEF = 16;
    localparam int TAIL_LEN_DEF = 3;

    // effect mode codes
    localparam logic [1:0] MODE_BREATH = 2'd0;
    localparam logic [1:0] MODE_CHASE  = 2'd1;
    localparam logic [1:0] MODE_OFF    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_GREEN = 2'd2;
    localparam logic [1:0] REG_BLUE  = 2'd3;

    localparam logic [7:0] BASE_RESET = 8'd150;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } prod_t;

    // exact x/255 for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // exact x/n for 8-bit x and n up to 8, recip is 2^16/n rounded up
    function automatic logic [7:0] div_tail(input logic [7:0] x, input logic [16:0] recip);
        logic [24:0] p;
        p = {17'd0, x} * {8'd0, recip};
        return p[23:16];
    endfunction

endpackage

// ----- src/lseg_pixel.sv -----
// per-pixel color logic: breathing scale, chase tail and off
module lseg_pixel #(
    parameter int NUM_LEDS = lseg_pkg::NUM_LEDS_DEF,
    parameter int TAIL_LEN = lseg_pkg::TAIL_LEN_DEF
) (
    input  logic [1:0]                                  mode,
    input  logic [((NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1)-1:0] led,
    input  logic [((NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1)-1:0] head,
    input  lseg_pkg::rgb_t                              base,
    input  lseg_pkg::rgb_t                              third,
    input  lseg_pkg::prod_t                             prod,
    output lseg_pkg::rgb_t                              color
);

    localparam int IDX_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int TAIL_W = (TAIL_LEN > 1) ? $clog2(TAIL_LEN) : 1;

    logic [IDX_W-1:0] behind;
    logic [IDX_W+3:0] behind_ext;
    logic [TAIL_W-1:0] tail_pos;
    logic             in_tail;

    assign behind     = head - led;
    assign behind_ext = {4'd0, behind};
    assign tail_pos   = behind_ext[TAIL_W-1:0];
    assign in_tail    = (led <= head) && (behind_ext < (IDX_W+4)'(TAIL_LEN));

    always_comb
    begin
        color = '0;
        case (mode)
            lseg_pkg::MODE_BREATH:
            begin
                color.red   = lseg_pkg::div255(prod.red);
                color.green = lseg_pkg::div255(prod.green);
                color.blue  = lseg_pkg::div255(prod.blue);
            end
            lseg_pkg::MODE_CHASE:
            begin
                if (in_tail)
                begin
                    // fade by base/TAIL_LEN (the third input) per step behind the head
                    color.red   = base.red   - 8'({8'd0, tail_pos} * {TAIL_W'(0), third.red});
                    color.green = base.green - 8'({8'd0, tail_pos} * {TAIL_W'(0), third.green});
                    color.blue  = base.blue  - 8'({8'd0, tail_pos} * {TAIL_W'(0), third.blue});
                end
            end
            default:
            begin
                color = '0;
            end
        endcase
    end

endmodule

// ----- src/led_strip_effect_generator_core.sv -----
// top level of the led strip effect generator: tick input, frame sequencer, pixel output
//
// Each accepted beat on s_axis with frame_tick set produces one frame: NUM_LEDS
// pixel beats on m_axis in LED order, the final one with tlast high. A beat with
// frame_tick clear is taken and dropped. effect_mode picks breathing (base color
// scaled by level/255, level then walks an 8-bit triangle), chase (head at the
// running position with a fading tail of TAIL_LEN LEDs, position then advances and
// wraps) or off (black; code 3 also reads as off). One pixel leaves per cycle unless
// m_axis_tready stalls; a frame is NUM_LEDS pixels (16 by default) from the pixel
// counter. One further tick is buffered while a frame runs and starts in the same
// cycle that the previous frame's last pixel is loaded, so frames stream without
// gaps. Configuration writes belong to idle time between frames.
`include "led_strip_effect_generator_core_macros.svh"

module led_strip_effect_generator_core #(
    parameter int NUM_LEDS = lseg_pkg::NUM_LEDS_DEF,
    parameter int TAIL_LEN = lseg_pkg::TAIL_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] frame_tick, [7:1] zero
    // pixel output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] led_index, [11:4] red, [19:12] green,
                                        // [27:20] blue, [31:28] zero
    output logic        m_axis_tlast    // last_pixel
);

    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(NUM_LEDS - 1);
    // rounded-up 2^16/TAIL_LEN, gives the tail step as a multiply and shift
    localparam logic [16:0] TAIL_RECIP = 17'((65536 + TAIL_LEN - 1) / TAIL_LEN);

    // configuration registers
    logic [1:0]     mode_reg;
    lseg_pkg::rgb_t base_reg;

    // effect state
    logic [7:0]       breath_level_reg, breath_level_next;
    logic             breath_falling_reg, breath_falling_next;
    logic [IDX_W-1:0] chase_pos_reg, chase_pos_next;

    // pending tick buffer
    logic pend_valid_reg, pend_valid_next;

    // frame sequencer
    logic             active_reg, active_next;
    logic [IDX_W-1:0] led_reg, led_next;
    logic [1:0]       frame_mode_reg;
    logic [IDX_W-1:0] frame_head_reg;
    lseg_pkg::prod_t  frame_prod_reg;
    lseg_pkg::rgb_t   frame_third_reg;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_led_reg;
    lseg_pkg::rgb_t   out_color_reg;
    logic             out_last_reg;

    logic             in_beat;
    logic             load_ok;
    logic             advance;
    logic             frame_done;
    logic             start;
    logic [7:0]       level_step;
    logic [IDX_W:0]   pos_inc;
    lseg_pkg::rgb_t   pix_color;
    logic [IDX_W+3:0] led_wide;

    assign s_axis_tready = !pend_valid_reg;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign load_ok    = !out_valid_reg || m_axis_tready;
    assign advance    = active_reg && load_ok;
    assign frame_done = advance && (led_reg == LAST_LED);
    assign start      = pend_valid_reg && (!active_reg || frame_done);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lseg_pkg::MODE_BREATH;
            base_reg.red   <= lseg_pkg::BASE_RESET;
            base_reg.green <= lseg_pkg::BASE_RESET;
            base_reg.blue  <= lseg_pkg::BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lseg_pkg::REG_MODE:  mode_reg       <= cfg_wdata[1:0];
                lseg_pkg::REG_RED:   base_reg.red   <= cfg_wdata;
                lseg_pkg::REG_GREEN: base_reg.green <= cfg_wdata;
                lseg_pkg::REG_BLUE:  base_reg.blue  <= cfg_wdata;
                default:             mode_reg       <= mode_reg;
            endcase
        end
    end

    // triangle step for breathing, wrap for chase
    assign level_step = breath_falling_reg ? (breath_level_reg - 8'd1)
                                           : (breath_level_reg + 8'd1);
    assign pos_inc    = {1'b0, chase_pos_reg} + {{IDX_W{1'b0}}, 1'b1};

    always_comb
    begin
        breath_level_next   = breath_level_reg;
        breath_falling_next = breath_falling_reg;
        chase_pos_next      = chase_pos_reg;
        if (start)
        begin
            case (mode_reg)
                lseg_pkg::MODE_BREATH:
                begin
                    breath_level_next = level_step;
                    if (level_step == 8'hFF)
                        breath_falling_next = 1'b1;
                    else if (level_step == 8'h00)
                        breath_falling_next = 1'b0;
                end
                lseg_pkg::MODE_CHASE:
                begin
                    chase_pos_next = (pos_inc >= (IDX_W+1)'(NUM_LEDS)) ? '0
                                                                      : pos_inc[IDX_W-1:0];
                end
                default:
                begin
                    chase_pos_next = chase_pos_reg;
                end
            endcase
        end
    end

    // tick buffer, sequencer and output valid
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (start)
            pend_valid_next = 1'b0;
        if (in_beat && s_axis_tdata[0])
            pend_valid_next = 1'b1;

        active_next = active_reg;
        led_next    = led_reg;
        if (advance)
        begin
            led_next = led_reg + IDX_W'(1);
            if (frame_done)
            begin
                active_next = 1'b0;
                led_next    = '0;
            end
        end
        if (start)
        begin
            active_next = 1'b1;
            led_next    = '0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            breath_level_reg   <= '0;
            breath_falling_reg <= 1'b0;
            chase_pos_reg      <= '0;
            pend_valid_reg     <= 1'b0;
            active_reg         <= 1'b0;
            led_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            breath_level_reg   <= breath_level_next;
            breath_falling_reg <= breath_falling_next;
            chase_pos_reg      <= chase_pos_next;
            pend_valid_reg     <= pend_valid_next;
            active_reg         <= active_next;
            led_reg            <= led_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // frame snapshot: products and tail steps are registered once per frame
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            frame_mode_reg        <= mode_reg;
            frame_head_reg        <= chase_pos_reg;
            frame_prod_reg.red    <= {8'd0, base_reg.red}   * {8'd0, breath_level_reg};
            frame_prod_reg.green  <= {8'd0, base_reg.green} * {8'd0, breath_level_reg};
            frame_prod_reg.blue   <= {8'd0, base_reg.blue}  * {8'd0, breath_level_reg};
            frame_third_reg.red   <= lseg_pkg::div_tail(base_reg.red, TAIL_RECIP);
            frame_third_reg.green <= lseg_pkg::div_tail(base_reg.green, TAIL_RECIP);
            frame_third_reg.blue  <= lseg_pkg::div_tail(base_reg.blue, TAIL_RECIP);
        end
    end

    lseg_pixel #(
        .NUM_LEDS (NUM_LEDS),
        .TAIL_LEN (TAIL_LEN)
    ) u_pixel (
        .mode  (frame_mode_reg),
        .led   (led_reg),
        .head  (frame_head_reg),
        .base  (base_reg),
        .third (frame_third_reg),
        .prod  (frame_prod_reg),
        .color (pix_color)
    );

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_led_reg   <= led_reg;
            out_color_reg <= pix_color;
            out_last_reg  <= (led_reg == LAST_LED);
        end
    end

    assign led_wide      = {4'd0, out_led_reg};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_color_reg.blue, out_color_reg.green,
                            out_color_reg.red, led_wide[3:0]};
    assign m_axis_tlast  = out_last_reg;

    // a waiting tick with the sequencer idle starts a frame at once
    `LSEG_ASSERT_NEXT(a_start_idle, clk, rst_n, pend_valid_reg && !active_reg, active_reg)
    // top of the triangle always turns downward
    `LSEG_ASSERT_IMPL(a_peak_falls, clk, rst_n, breath_level_reg == 8'hFF, breath_falling_reg)
    // bottom of the triangle always turns upward
    `LSEG_ASSERT_IMPL(a_floor_rises, clk, rst_n, breath_level_reg == 8'h00, !breath_falling_reg)
    // idle sequencer sits at the first led
    `LSEG_ASSERT_IMPL(a_idle_led0, clk, rst_n, !active_reg, led_reg == '0)

endmodule
